// ===== hw/rtl/dpd_pkg.sv =====
package dpd_pkg;

    // Field and register widths
    localparam int CharW       = 8;
    localparam int LetterW     = 7;
    localparam int SymW        = 3;
    localparam int IdxW        = 5;
    localparam int CodeW       = 5;
    localparam int CfgIdxW     = 3;
    localparam int CfgDataW    = 45;
    localparam int FirstLowW   = 39;
    localparam int FirstHighW  = 36;
    localparam int SecondAW    = 45;
    localparam int SecondBW    = 45;
    localparam int SecondCW    = 35;
    localparam int FirstBoxW   = FirstLowW + FirstHighW;
    localparam int SecondBoxW  = SecondAW + SecondBW + SecondCW;

    // Register indexes
    localparam logic [CfgIdxW-1:0] CfgFirstLow  = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgFirstHigh = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgSecondA   = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgSecondB   = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgSecondC   = 3'd4;

    // Character and code constants
    localparam logic [CharW-1:0]   CharZero  = 8'h30;
    localparam logic [CharW-1:0]   CharOne   = 8'h31;
    localparam logic [CharW-1:0]   CharFive  = 8'h35;
    localparam logic [CharW-1:0]   CharSix   = 8'h36;
    localparam logic [CharW-1:0]   CharNine  = 8'h39;
    localparam logic [SymW-1:0]    SymLast   = 3'd4;
    localparam logic [SymW-1:0]    SymNull   = 3'd5;
    localparam logic [CodeW-1:0]   CodeMax   = 5'd25;
    localparam logic [LetterW-1:0] LetterA   = 7'd65;
    localparam logic [LetterW-1:0] LetterZ   = 7'd90;
    localparam logic [IdxW-1:0]    SquareDim = 5'd5;

    typedef struct packed {
        logic [FirstBoxW-1:0]  first_box;
        logic [SecondBoxW-1:0] second_box;
    } t_cfg;

    typedef struct packed {
        logic            valid;
        logic [SymW-1:0] sym;
    } t_digit;

    typedef struct packed {
        logic               valid;
        logic [LetterW-1:0] letter;
    } t_result;

    // Map a digit character to its symbol; other characters are dropped
    function automatic t_digit digit_symbol(input logic [CharW-1:0] ch);
        t_digit d;
        d.valid = 1'b1;
        d.sym   = '0;
        if (ch >= CharSix && ch <= CharNine) begin
            d.sym = SymW'(ch - CharSix);
        end else if (ch == CharZero) begin
            d.sym = SymLast;
        end else if (ch >= CharOne && ch <= CharFive) begin
            d.sym = SymW'(ch - CharOne);
        end else begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

    // Square index from a pair of symbols (row * 5 + column)
    function automatic logic [IdxW-1:0] pair_index(input logic [SymW-1:0] row,
                                                   input logic [SymW-1:0] col);
        return IdxW'(row) * SquareDim + IdxW'(col);
    endfunction

endpackage

// ===== hw/rtl/dpd_cfg_regs.sv =====
module dpd_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dpd_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [dpd_pkg::CfgDataW-1:0]   i_cfg_data,
    output dpd_pkg::t_cfg                  o_cfg
);

    logic [dpd_pkg::FirstLowW-1:0]  r_first_low;
    logic [dpd_pkg::FirstHighW-1:0] r_first_high;
    logic [dpd_pkg::SecondAW-1:0]   r_second_a;
    logic [dpd_pkg::SecondBW-1:0]   r_second_b;
    logic [dpd_pkg::SecondCW-1:0]   r_second_c;

    assign o_cfg_ready = 1'b1;

    // Take a write beat, truncating data to the register width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_low  <= '1;
            r_first_high <= '1;
            r_second_a   <= '0;
            r_second_b   <= '0;
            r_second_c   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dpd_pkg::CfgFirstLow:  r_first_low  <= i_cfg_data[dpd_pkg::FirstLowW-1:0];
                dpd_pkg::CfgFirstHigh: r_first_high <= i_cfg_data[dpd_pkg::FirstHighW-1:0];
                dpd_pkg::CfgSecondA:   r_second_a   <= i_cfg_data[dpd_pkg::SecondAW-1:0];
                dpd_pkg::CfgSecondB:   r_second_b   <= i_cfg_data[dpd_pkg::SecondBW-1:0];
                dpd_pkg::CfgSecondC:   r_second_c   <= i_cfg_data[dpd_pkg::SecondCW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.first_box  = {r_first_high, r_first_low};
    assign o_cfg.second_box = {r_second_c, r_second_b, r_second_a};

endmodule

// ===== hw/rtl/dpd_step.sv =====
module dpd_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [dpd_pkg::CharW-1:0]   i_char_code,
    input  logic                        i_end_of_message,
    input  dpd_pkg::t_cfg               i_cfg,
    output dpd_pkg::t_result            o_result
);

    logic                       r_raw_valid;
    logic [dpd_pkg::SymW-1:0]   r_raw_half;
    logic                       r_mid_valid;
    logic [dpd_pkg::SymW-1:0]   r_mid_half;
    logic                       n_raw_valid;
    logic [dpd_pkg::SymW-1:0]   n_raw_half;
    logic                       n_mid_valid;
    logic [dpd_pkg::SymW-1:0]   n_mid_half;

    dpd_pkg::t_digit            digit;
    logic [dpd_pkg::IdxW-1:0]   first_idx;
    logic [dpd_pkg::IdxW-1:0]   second_idx;
    logic [dpd_pkg::SymW-1:0]   mid_digit;
    logic [dpd_pkg::CodeW-1:0]  code;
    logic [dpd_pkg::CodeW-1:0]  code_sat;

    // Look up both boxes
    always_comb begin
        digit      = dpd_pkg::digit_symbol(i_char_code);
        first_idx  = dpd_pkg::pair_index(r_raw_half, digit.sym);
        mid_digit  = i_cfg.first_box[first_idx * 3 +: dpd_pkg::SymW];
        second_idx = dpd_pkg::pair_index(r_mid_half, mid_digit);
        code       = i_cfg.second_box[second_idx * 5 +: dpd_pkg::CodeW];
        code_sat   = (code > dpd_pkg::CodeMax) ? dpd_pkg::CodeMax : code;
    end

    // Advance the pending halves and form the result
    always_comb begin
        n_raw_valid     = r_raw_valid;
        n_raw_half      = r_raw_half;
        n_mid_valid     = r_mid_valid;
        n_mid_half      = r_mid_half;
        o_result.valid  = 1'b0;
        o_result.letter = dpd_pkg::LetterA + dpd_pkg::LetterW'(code_sat);
        if (digit.valid) begin
            if (!r_raw_valid) begin
                n_raw_half  = digit.sym;
                n_raw_valid = 1'b1;
            end else begin
                n_raw_valid = 1'b0;
                if (mid_digit < dpd_pkg::SymNull) begin
                    if (!r_mid_valid) begin
                        n_mid_half  = mid_digit;
                        n_mid_valid = 1'b1;
                    end else begin
                        n_mid_valid    = 1'b0;
                        o_result.valid = 1'b1;
                    end
                end
            end
        end
        // Drop odd leftovers at end of message
        if (i_end_of_message) begin
            n_raw_valid = 1'b0;
            n_mid_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_valid <= 1'b0;
            r_raw_half  <= '0;
            r_mid_valid <= 1'b0;
            r_mid_half  <= '0;
        end else if (i_fire) begin
            r_raw_valid <= n_raw_valid;
            r_raw_half  <= n_raw_half;
            r_mid_valid <= n_mid_valid;
            r_mid_half  <= n_mid_half;
        end
    end

endmodule

// ===== hw/rtl/double_polybius_decoder.sv =====
// Path: an accepted character beat is held in the input register, passes the box
// lookup and is then registered in the result register.
// Throughput: one character per cycle unless the result register is stalled; the
// input register feeds the box lookup and the result register in a single pass.
// Reset: synchronous active-low i_rst_n clears pending halves and both valid
// flags, sets the first box to all null and the second box to zero.
module double_polybius_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [dpd_pkg::CharW-1:0]    i_char_code,
    input  logic                         i_end_of_message,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [dpd_pkg::LetterW-1:0]  o_letter,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [dpd_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [dpd_pkg::CfgDataW-1:0] i_cfg_data
);

    dpd_pkg::t_cfg              cfg;
    dpd_pkg::t_result           result;
    logic                       r_in_valid;
    logic [dpd_pkg::CharW-1:0]  r_char;
    logic                       r_eom;
    logic                       r_out_valid;
    logic [dpd_pkg::LetterW-1:0] r_letter;
    logic                       out_free;
    logic                       fire;

    dpd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dpd_step u_step (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (fire),
        .i_char_code      (r_char),
        .i_end_of_message (r_eom),
        .i_cfg            (cfg),
        .o_result         (result)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    // Hold the input beat until the result stage can take it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_char <= i_char_code;
            r_eom  <= i_end_of_message;
        end
    end

    // Load the result register or drain it on a taken beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= result.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && result.valid) begin
            r_letter <= result.letter;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_letter    = r_letter;

    // A delivered letter is always within A to Z
    a_letter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_letter >= dpd_pkg::LetterA && o_letter <= dpd_pkg::LetterZ))
        else $error("letter out of range");

    // A new result beat only follows a held input beat
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid))
        else $error("result without input");

    // A full input register behind a stalled result blocks new beats
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while pipeline full");

endmodule
